// ===== sv/bba_pkg.sv =====
// ----------------------------------------------------------------------------
// bba_pkg - buddy block allocator shared definitions
// Types, sizes and status codes used across the allocator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package bba_pkg;

  // pool geometry
  localparam int LOG2_BLOCKS  = 10;
  localparam int NBLK         = 1 << LOG2_BLOCKS;
  localparam int NORD         = LOG2_BLOCKS + 1;
  localparam int BLOCK_SHIFT  = 4;
  localparam int POOL_BYTES   = 1 << (LOG2_BLOCKS + BLOCK_SHIFT);

  localparam int ORD_W        = 4;
  localparam int IDX_W        = LOG2_BLOCKS;
  localparam int CNT_W        = IDX_W + 1;
  localparam int HEAD_W       = ORD_W + 1;

  // free marks are kept as rows of bits, one row address per (order, row)
  localparam int ROW_W        = 32;
  localparam int BIT_W        = 5;
  localparam int ROW_SEL_W    = IDX_W - BIT_W;
  localparam int ROWS_PER_ORD = NBLK / ROW_W;
  localparam int MARK_ROWS    = NORD * ROWS_PER_ORD;
  localparam int ROW_ADDR_W   = ORD_W + ROW_SEL_W;

  // status codes
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_REJECT  = 2'd2;

  // actions
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  typedef struct packed {
    logic        action;
    logic [15:0] request_bytes;
    logic [15:0] free_offset;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [13:0] block_offset;
    logic [3:0]  block_order;
  } out_item_t;

endpackage

`default_nettype wire

// ===== sv/buddy_block_allocator_top.sv =====
// ----------------------------------------------------------------------------
// buddy_block_allocator_top - binary buddy allocator
// Allocates and frees power-of-two blocks of a 16 KiB pool of 16-byte blocks.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over its tables and takes no
// transaction until it ends. One request is worked at a time by a sequencer
// that makes one free-mark row access per step. An allocate searches the
// orders upward, scans up to 32 mark rows of the order it finds and then
// splits down to the asked order; a free merges with free buddies, at most
// up to the whole pool.
// The mark row scan and the one read port of each table set how long each takes.
// A finished result waits in an output register, so the next request can be
// taken while the previous result is still pending.
`default_nettype none

module buddy_block_allocator_top (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire bba_pkg::in_item_t   in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output bba_pkg::out_item_t       out_data
);

  logic               res_valid;
  logic               res_ready;
  bba_pkg::out_item_t res_data;
  logic               out_valid_r;
  bba_pkg::out_item_t out_data_r;

  bba_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_ready  (in_ready),
    .res_valid (res_valid),
    .res_data  (res_data),
    .res_ready (res_ready)
  );

  // output register takes a result when empty or draining
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ===== sv/bba_ram.sv =====
// ----------------------------------------------------------------------------
// bba_ram - generic single write, single read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== sv/bba_ffs.sv =====
// ----------------------------------------------------------------------------
// bba_ffs - lowest set bit finder
// Gives the position of the lowest set bit of one free mark row.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_ffs (
  input  wire logic [bba_pkg::ROW_W-1:0] word,
  output logic      [bba_pkg::BIT_W-1:0] pos
);

  // priority encode from the top so the lowest set bit wins
  always_comb begin
    pos = '0;
    for (int i = bba_pkg::ROW_W - 1; i >= 0; i--) begin
      if (word[i]) begin
        pos = bba_pkg::BIT_W'(i);
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/bba_core.sv =====
// ----------------------------------------------------------------------------
// bba_core - buddy allocator sequencer
// Walks the free mark rows and block head table, at most one access to each per step.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_core (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  input  wire bba_pkg::in_item_t    in_data,
  output logic                      in_ready,
  output logic                      res_valid,
  output bba_pkg::out_item_t        res_data,
  input  wire logic                 res_ready
);

  localparam int IW = bba_pkg::IDX_W;
  localparam int OW = bba_pkg::ORD_W;
  localparam int BW = bba_pkg::BIT_W;
  localparam int RA = bba_pkg::ROW_ADDR_W;

  localparam logic [3:0] S_INIT   = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_A_ORD  = 4'd2;
  localparam logic [3:0] S_A_FIND = 4'd3;
  localparam logic [3:0] S_A_RD   = 4'd4;
  localparam logic [3:0] S_A_CHK  = 4'd5;
  localparam logic [3:0] S_SPLIT  = 4'd6;
  localparam logic [3:0] S_S_WR   = 4'd7;
  localparam logic [3:0] S_F_HEAD = 4'd8;
  localparam logic [3:0] S_F_MARK = 4'd9;
  localparam logic [3:0] S_F_CHK  = 4'd10;
  localparam logic [3:0] S_M_RD   = 4'd11;
  localparam logic [3:0] S_M_EVAL = 4'd12;
  localparam logic [3:0] S_E_WR   = 4'd13;
  localparam logic [3:0] S_DONE   = 4'd14;

  localparam logic [OW-1:0] TOP_ORD = OW'(bba_pkg::LOG2_BLOCKS);
  localparam logic [RA-1:0] TOP_ROW =
    RA'(bba_pkg::LOG2_BLOCKS * bba_pkg::ROWS_PER_ORD);
  localparam logic [IW-1:0] LAST_CLR = IW'(bba_pkg::NBLK - 1);

  logic [3:0]                   state_r, state_nxt;
  logic [IW-1:0]                clr_r, clr_nxt;
  bba_pkg::in_item_t            req_r, req_nxt;
  logic [OW-1:0]                ord_r, ord_nxt;
  logic [OW-1:0]                o_r, o_nxt;
  logic [IW-1:0]                idx_r, idx_nxt;
  logic [IW-1:0]                tgt_r, tgt_nxt;
  logic [bba_pkg::ROW_SEL_W-1:0] row_r, row_nxt;
  bba_pkg::out_item_t           res_r, res_nxt;
  logic [bba_pkg::CNT_W-1:0]    cnt_r [bba_pkg::NORD];

  // memory ports
  logic                         mark_we;
  logic [RA-1:0]                mark_wa, mark_ra;
  logic [bba_pkg::ROW_W-1:0]    mark_wd, mark_rd;
  logic                         head_we;
  logic [IW-1:0]                head_wa, head_ra;
  logic [bba_pkg::HEAD_W-1:0]   head_wd, head_rd;

  // free count update, one order per cycle
  logic                         cnt_inc, cnt_dec;
  logic [OW-1:0]                cnt_ord;
  logic [bba_pkg::CNT_W-1:0]    cnt_sel;

  logic [BW-1:0]                ffs_pos;
  logic                         too_big;
  logic [15:0]                  size_m1;
  logic [11:0]                  size_q;
  logic [OW-1:0]                ord_calc;
  logic                         off_bad;
  logic [IW-1:0]                off_idx;
  logic [IW-1:0]                bud_idx;
  logic [IW-1:0]                up_idx;
  logic [OW-1:0]                o_dn;

  bba_ram #(
    .WIDTH (bba_pkg::ROW_W),
    .DEPTH (bba_pkg::MARK_ROWS)
  ) u_mark_ram (
    .clk   (clk),
    .we    (mark_we),
    .waddr (mark_wa),
    .wdata (mark_wd),
    .raddr (mark_ra),
    .rdata (mark_rd)
  );

  bba_ram #(
    .WIDTH (bba_pkg::HEAD_W),
    .DEPTH (bba_pkg::NBLK)
  ) u_head_ram (
    .clk   (clk),
    .we    (head_we),
    .waddr (head_wa),
    .wdata (head_wd),
    .raddr (head_ra),
    .rdata (head_rd)
  );

  bba_ffs u_ffs (
    .word (mark_rd),
    .pos  (ffs_pos)
  );

  // size to order rounding
  always_comb begin
    too_big  = {1'b0, req_r.request_bytes} > 17'(bba_pkg::POOL_BYTES);
    size_m1  = (req_r.request_bytes == 16'd0) ? 16'd0 : req_r.request_bytes - 16'd1;
    size_q   = size_m1[15:bba_pkg::BLOCK_SHIFT];
    ord_calc = '0;
    for (int i = 0; i < 12; i++) begin
      if (size_q[i]) begin
        ord_calc = OW'(i + 1);
      end
    end
  end

  // free offset checks and index arithmetic
  always_comb begin
    off_bad = (req_r.free_offset[15:14] != 2'd0) ||
              (req_r.free_offset[bba_pkg::BLOCK_SHIFT-1:0] != '0);
    off_idx = req_r.free_offset[IW+bba_pkg::BLOCK_SHIFT-1:bba_pkg::BLOCK_SHIFT];
    bud_idx = idx_r ^ (IW'(1) << o_r);
    o_dn    = o_r - OW'(1);
    up_idx  = idx_r | (IW'(1) << o_dn);
  end

  // free count of the order under search
  always_comb begin
    cnt_sel = '0;
    for (int i = 0; i < bba_pkg::NORD; i++) begin
      if (o_r == OW'(i)) begin
        cnt_sel = cnt_r[i];
      end
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    req_nxt   = req_r;
    ord_nxt   = ord_r;
    o_nxt     = o_r;
    idx_nxt   = idx_r;
    tgt_nxt   = tgt_r;
    row_nxt   = row_r;
    res_nxt   = res_r;
    mark_we   = 1'b0;
    mark_wa   = '0;
    mark_wd   = '0;
    mark_ra   = '0;
    head_we   = 1'b0;
    head_wa   = '0;
    head_wd   = '0;
    head_ra   = '0;
    cnt_inc   = 1'b0;
    cnt_dec   = 1'b0;
    cnt_ord   = o_r;
    in_ready  = 1'b0;
    res_valid = 1'b0;

    unique case (state_r)
      S_INIT: begin
        // clearing pass, seeding the whole pool as one free block
        head_we = 1'b1;
        head_wa = clr_r;
        head_wd = (clr_r == '0) ? {1'b1, TOP_ORD} : '0;
        mark_we = ({1'b0, clr_r} < (IW + 1)'(bba_pkg::MARK_ROWS));
        mark_wa = clr_r[RA-1:0];
        mark_wd = (clr_r[RA-1:0] == TOP_ROW) ? bba_pkg::ROW_W'(1) : '0;
        clr_nxt = clr_r + IW'(1);
        if (clr_r == LAST_CLR) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          req_nxt   = in_data;
          state_nxt = (in_data.action == bba_pkg::ACT_ALLOC) ? S_A_ORD : S_F_HEAD;
        end
      end

      S_A_ORD: begin
        if (too_big) begin
          res_nxt   = '{status: bba_pkg::ST_NOSPACE, block_offset: '0, block_order: '0};
          state_nxt = S_DONE;
        end else begin
          ord_nxt   = ord_calc;
          o_nxt     = ord_calc;
          state_nxt = S_A_FIND;
        end
      end

      // lowest order at or above the target with a free block
      S_A_FIND: begin
        if (o_r > TOP_ORD) begin
          res_nxt   = '{status: bba_pkg::ST_NOSPACE, block_offset: '0, block_order: '0};
          state_nxt = S_DONE;
        end else if (cnt_sel != '0) begin
          row_nxt   = '0;
          state_nxt = S_A_RD;
        end else begin
          o_nxt = o_r + OW'(1);
        end
      end

      S_A_RD: begin
        mark_ra   = {o_r, row_r};
        state_nxt = S_A_CHK;
      end

      // take the lowest free block in the first non-empty row
      S_A_CHK: begin
        if (mark_rd != '0) begin
          mark_we   = 1'b1;
          mark_wa   = {o_r, row_r};
          mark_wd   = mark_rd & ~(bba_pkg::ROW_W'(1) << ffs_pos);
          cnt_dec   = 1'b1;
          idx_nxt   = {row_r, ffs_pos};
          state_nxt = S_SPLIT;
        end else begin
          row_nxt   = row_r + 1'b1;
          state_nxt = S_A_RD;
        end
      end

      // split down one order, or finish
      S_SPLIT: begin
        if (o_r == ord_r) begin
          head_we   = 1'b1;
          head_wa   = idx_r;
          head_wd   = {1'b1, ord_r};
          res_nxt   = '{status: bba_pkg::ST_DONE,
                        block_offset: {idx_r, bba_pkg::BLOCK_SHIFT'(0)},
                        block_order: ord_r};
          state_nxt = S_DONE;
        end else begin
          o_nxt     = o_dn;
          tgt_nxt   = up_idx;
          mark_ra   = {o_dn, up_idx[IW-1:BW]};
          state_nxt = S_S_WR;
        end
      end

      // upper half becomes a free block
      S_S_WR: begin
        mark_we   = 1'b1;
        mark_wa   = {o_r, tgt_r[IW-1:BW]};
        mark_wd   = mark_rd | (bba_pkg::ROW_W'(1) << tgt_r[BW-1:0]);
        cnt_inc   = 1'b1;
        head_we   = 1'b1;
        head_wa   = tgt_r;
        head_wd   = {1'b1, o_r};
        state_nxt = S_SPLIT;
      end

      S_F_HEAD: begin
        if (off_bad) begin
          res_nxt   = '{status: bba_pkg::ST_REJECT, block_offset: '0, block_order: '0};
          state_nxt = S_DONE;
        end else begin
          idx_nxt   = off_idx;
          head_ra   = off_idx;
          state_nxt = S_F_MARK;
        end
      end

      S_F_MARK: begin
        if (!head_rd[bba_pkg::HEAD_W-1] || (head_rd[OW-1:0] > TOP_ORD)) begin
          res_nxt   = '{status: bba_pkg::ST_REJECT, block_offset: '0, block_order: '0};
          state_nxt = S_DONE;
        end else begin
          o_nxt     = head_rd[OW-1:0];
          mark_ra   = {head_rd[OW-1:0], idx_r[IW-1:BW]};
          state_nxt = S_F_CHK;
        end
      end

      // already free is a reject
      S_F_CHK: begin
        if (mark_rd[idx_r[BW-1:0]]) begin
          res_nxt   = '{status: bba_pkg::ST_REJECT, block_offset: '0, block_order: '0};
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_M_RD;
        end
      end

      // fetch the buddy, or go mark the final block
      S_M_RD: begin
        if (o_r == TOP_ORD) begin
          mark_ra   = {o_r, idx_r[IW-1:BW]};
          state_nxt = S_E_WR;
        end else begin
          tgt_nxt   = bud_idx;
          mark_ra   = {o_r, bud_idx[IW-1:BW]};
          head_ra   = bud_idx;
          state_nxt = S_M_EVAL;
        end
      end

      // merge with a free buddy of the same order
      S_M_EVAL: begin
        if (mark_rd[tgt_r[BW-1:0]] && head_rd[bba_pkg::HEAD_W-1] &&
            (head_rd[OW-1:0] == o_r)) begin
          mark_we   = 1'b1;
          mark_wa   = {o_r, tgt_r[IW-1:BW]};
          mark_wd   = mark_rd & ~(bba_pkg::ROW_W'(1) << tgt_r[BW-1:0]);
          cnt_dec   = 1'b1;
          head_we   = 1'b1;
          head_wa   = (idx_r < tgt_r) ? tgt_r : idx_r;
          head_wd   = '0;
          idx_nxt   = (idx_r < tgt_r) ? idx_r : tgt_r;
          o_nxt     = o_r + OW'(1);
          state_nxt = S_M_RD;
        end else begin
          mark_ra   = {o_r, idx_r[IW-1:BW]};
          state_nxt = S_E_WR;
        end
      end

      S_E_WR: begin
        mark_we   = 1'b1;
        mark_wa   = {o_r, idx_r[IW-1:BW]};
        mark_wd   = mark_rd | (bba_pkg::ROW_W'(1) << idx_r[BW-1:0]);
        cnt_inc   = 1'b1;
        head_we   = 1'b1;
        head_wa   = idx_r;
        head_wd   = {1'b1, o_r};
        res_nxt   = '{status: bba_pkg::ST_DONE,
                      block_offset: {idx_r, bba_pkg::BLOCK_SHIFT'(0)},
                      block_order: o_r};
        state_nxt = S_DONE;
      end

      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign res_data = res_r;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
    end
  end

  // per-order free counts
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < bba_pkg::NORD; i++) begin
        cnt_r[i] <= (i == bba_pkg::LOG2_BLOCKS) ? bba_pkg::CNT_W'(1) : '0;
      end
    end else begin
      for (int i = 0; i < bba_pkg::NORD; i++) begin
        if (cnt_ord == OW'(i)) begin
          if (cnt_inc) begin
            cnt_r[i] <= cnt_r[i] + 1'b1;
          end else if (cnt_dec) begin
            cnt_r[i] <= cnt_r[i] - 1'b1;
          end
        end
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    req_r <= req_nxt;
    ord_r <= ord_nxt;
    o_r   <= o_nxt;
    idx_r <= idx_nxt;
    tgt_r <= tgt_nxt;
    row_r <= row_nxt;
    res_r <= res_nxt;
  end

endmodule

`default_nettype wire
